// ===== rtl/core/alie_pkg.sv =====
// alie_pkg: shared types, constants and mnemonic lookup functions for the
// assembly line instruction encoder. No dependencies.

package alie_pkg;

  // address width as configured, and the part of it that fits the word
  localparam int unsigned ADDR_BITS = 15;
  localparam int unsigned EFF_BITS  = (ADDR_BITS < 1) ? 1 :
                                      ((ADDR_BITS > 15) ? 15 : ADDR_BITS);
  localparam logic [EFF_BITS-1:0] ADDR_MAX = {EFF_BITS{1'b1}};

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // character classes
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_AT    = 3'd2,
    CLS_EQ    = 3'd3,
    CLS_SEMI  = 3'd4
  } chr_cls_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_DEST     = 3'd1,
    ERR_COMP     = 3'd2,
    ERR_JUMP     = 3'd3,
    ERR_ADDR_OVF = 3'd4,
    ERR_DIGIT    = 3'd5
  } err_e;

  // instruction kinds
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_COMP = 2'd2
  } kind_e;

  // one classified character in the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    chr_cls_e   cls;
    logic [3:0] digit;
  } qentry_t;

  // one encoded line
  typedef struct packed {
    logic [15:0] word;
    kind_e       kind;
    err_e        err;
  } result_t;

  // comp lookup answer
  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } comp_hit_t;

  // dest mnemonic, zero on miss
  function automatic logic [2:0] dest_lookup(logic [23:0] chars, logic [2:0] len);
    logic [2:0] code;
    code = 3'd0;
    unique case (len)
      3'd1: begin
        unique case (chars[7:0])
          "M":     code = 3'd1;
          "D":     code = 3'd2;
          "A":     code = 3'd4;
          default: code = 3'd0;
        endcase
      end
      3'd2: begin
        unique case ({chars[7:0], chars[15:8]})
          "MD":    code = 3'd3;
          "AM":    code = 3'd5;
          "AD":    code = 3'd6;
          default: code = 3'd0;
        endcase
      end
      3'd3: begin
        code = ({chars[7:0], chars[15:8], chars[23:16]} == "AMD") ? 3'd7 : 3'd0;
      end
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  // jump mnemonic, zero on miss
  function automatic logic [2:0] jump_lookup(logic [23:0] chars, logic [2:0] len);
    logic [2:0] code;
    code = 3'd0;
    if (len == 3'd3) begin
      unique case ({chars[7:0], chars[15:8], chars[23:16]})
        "JGT":   code = 3'd1;
        "JEQ":   code = 3'd2;
        "JGE":   code = 3'd3;
        "JLT":   code = 3'd4;
        "JNE":   code = 3'd5;
        "JLE":   code = 3'd6;
        "JMP":   code = 3'd7;
        default: code = 3'd0;
      endcase
    end
    return code;
  endfunction

  // comp mnemonic, a bit included
  function automatic comp_hit_t comp_lookup(logic [23:0] chars, logic [2:0] len);
    comp_hit_t r;
    r = '{hit: 1'b1, code: 7'h00};
    unique case (len)
      3'd1: begin
        unique case (chars[7:0])
          "0":     r.code = 7'h2A;
          "1":     r.code = 7'h3F;
          "D":     r.code = 7'h0C;
          "A":     r.code = 7'h30;
          "M":     r.code = 7'h70;
          default: r.hit  = 1'b0;
        endcase
      end
      3'd2: begin
        unique case ({chars[7:0], chars[15:8]})
          "-1":    r.code = 7'h3A;
          "!D":    r.code = 7'h0D;
          "!A":    r.code = 7'h31;
          "-D":    r.code = 7'h0F;
          "-A":    r.code = 7'h33;
          "!M":    r.code = 7'h71;
          "-M":    r.code = 7'h73;
          default: r.hit  = 1'b0;
        endcase
      end
      3'd3: begin
        unique case ({chars[7:0], chars[15:8], chars[23:16]})
          "D+1", "1+D": r.code = 7'h1F;
          "A+1", "1+A": r.code = 7'h37;
          "D-1":        r.code = 7'h0E;
          "A-1":        r.code = 7'h32;
          "D+A", "A+D": r.code = 7'h02;
          "D-A":        r.code = 7'h13;
          "A-D":        r.code = 7'h07;
          "D&A", "A&D": r.code = 7'h00;
          "D|A", "A|D": r.code = 7'h15;
          "M+1", "1+M": r.code = 7'h77;
          "M-1":        r.code = 7'h72;
          "D+M", "M+D": r.code = 7'h42;
          "D-M":        r.code = 7'h53;
          "M-D":        r.code = 7'h47;
          "D&M", "M&D": r.code = 7'h40;
          "D|M", "M|D": r.code = 7'h55;
          default:      r.hit  = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/alie_front.sv =====
// alie_front: input beat acceptance and character classification.
// Depends on alie_pkg.

module alie_front
  import alie_pkg::*;
(
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] ch
  input  logic       s_axis_tlast,  // last
  input  logic       q_full_i,
  output logic       q_push_o,
  output qentry_t    q_entry_o
);

  // take a beat whenever the queue has room
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // classify the character
  always_comb begin
    q_entry_o.ch    = s_axis_tdata;
    q_entry_o.last  = s_axis_tlast;
    q_entry_o.digit = s_axis_tdata[3:0] - 4'd0;
    if (s_axis_tdata >= "0" && s_axis_tdata <= "9") begin
      q_entry_o.cls = CLS_DIGIT;
    end else if (s_axis_tdata == "@") begin
      q_entry_o.cls = CLS_AT;
    end else if (s_axis_tdata == "=") begin
      q_entry_o.cls = CLS_EQ;
    end else if (s_axis_tdata == ";") begin
      q_entry_o.cls = CLS_SEMI;
    end else begin
      q_entry_o.cls = CLS_OTHER;
    end
  end

endmodule

// ===== rtl/core/alie_queue.sv =====
// alie_queue: short queue of classified characters between front and back.
// Depends on alie_pkg.

module alie_queue
  import alie_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t entry_i,
  output logic    full_o,
  input  logic    pop_i,
  output qentry_t entry_o,
  output logic    empty_o
);

  qentry_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/alie_back.sv =====
// alie_back: line parser, mnemonic matching and result register.
// Depends on alie_pkg.

module alie_back
  import alie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  qentry_t     q_entry_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] word, [18:16] error, zero pad
  output logic [1:0]  m_axis_tuser   // [1:0] kind
);

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_ADDR  = 3'b010,
    PH_OTHER = 3'b100
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [23:0]         tok_chars_q, tok_chars_d;
  logic [2:0]          tok_len_q, tok_len_d;
  logic [2:0]          dest_q, dest_d;
  logic [6:0]          comp_q, comp_d;
  logic [EFF_BITS-1:0] addr_q, addr_d;
  err_e                err_q, err_d;
  logic                seen_eq_q, seen_eq_d;
  logic                seen_semi_q, seen_semi_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;
  result_t             res;
  logic                slot_free;

  function automatic err_e note_err(err_e cur, err_e code);
    return (cur == ERR_OK) ? code : cur;
  endfunction

  // a last character needs a free result slot
  assign slot_free = !out_valid_q || m_axis_tready;
  assign q_pop_o   = !q_empty_i && (!q_entry_i.last || slot_free);

  // per-character parse step and line-end encoding
  always_comb begin
    logic [EFF_BITS+3:0] prod;
    comp_hit_t           cres;
    logic [2:0]          dcode;
    logic [2:0]          jcode;
    phase_e              ph;

    ph          = phase_q;
    tok_chars_d = tok_chars_q;
    tok_len_d   = tok_len_q;
    dest_d      = dest_q;
    comp_d      = comp_q;
    addr_d      = addr_q;
    err_d       = err_q;
    seen_eq_d   = seen_eq_q;
    seen_semi_d = seen_semi_q;
    res         = '{word: 16'd0, kind: KIND_NONE, err: ERR_OK};
    prod        = ({4'd0, addr_q} << 3) + ({4'd0, addr_q} << 1)
                  + (EFF_BITS + 4)'(q_entry_i.digit);
    cres        = '{hit: 1'b0, code: 7'd0};
    dcode       = 3'd0;
    jcode       = 3'd0;

    // line kind is fixed by the first character
    if (phase_q == PH_START) begin
      ph = (q_entry_i.cls == CLS_AT) ? PH_ADDR : PH_OTHER;
    end

    if (ph == PH_ADDR) begin
      // address line: leading at sign, then decimal digits
      if (q_entry_i.cls == CLS_AT && tok_len_q == 3'd0 && err_q == ERR_OK &&
          addr_q == '0 && !seen_eq_q) begin
        seen_eq_d = 1'b1;
      end else if (q_entry_i.cls == CLS_DIGIT) begin
        tok_len_d = 3'd1;
        if (prod > (EFF_BITS + 4)'(ADDR_MAX)) begin
          addr_d = ADDR_MAX;
          err_d  = note_err(err_q, ERR_ADDR_OVF);
        end else begin
          addr_d = prod[EFF_BITS-1:0];
        end
      end else begin
        err_d = note_err(err_q, ERR_DIGIT);
      end
    end else begin
      // compute line: split at separators, collect token characters
      if (q_entry_i.cls == CLS_EQ && !seen_eq_q && !seen_semi_q) begin
        dcode     = dest_lookup(tok_chars_q, tok_len_q);
        seen_eq_d = 1'b1;
        if (dcode == 3'd0) begin
          err_d = note_err(err_q, ERR_DEST);
        end else begin
          dest_d = dcode;
        end
        tok_chars_d = '0;
        tok_len_d   = 3'd0;
      end else if (q_entry_i.cls == CLS_SEMI && !seen_semi_q) begin
        cres        = comp_lookup(tok_chars_q, tok_len_q);
        seen_semi_d = 1'b1;
        if (!cres.hit) begin
          err_d = note_err(err_q, ERR_COMP);
        end else begin
          comp_d = cres.code;
        end
        tok_chars_d = '0;
        tok_len_d   = 3'd0;
      end else begin
        unique case (tok_len_q)
          3'd0: begin
            tok_chars_d[7:0] = q_entry_i.ch;
            tok_len_d        = 3'd1;
          end
          3'd1: begin
            tok_chars_d[15:8] = q_entry_i.ch;
            tok_len_d         = 3'd2;
          end
          3'd2: begin
            tok_chars_d[23:16] = q_entry_i.ch;
            tok_len_d          = 3'd3;
          end
          default: tok_len_d = 3'd4;
        endcase
      end
    end

    // line end: finish matching and build the result
    if (q_entry_i.last) begin
      if (ph == PH_ADDR) begin
        if (tok_len_d == 3'd0) begin
          err_d = note_err(err_d, ERR_DIGIT);
        end
        res.kind = KIND_ADDR;
        res.err  = err_d;
        res.word = (err_d == ERR_DIGIT) ? 16'd0 : 16'(addr_d);
      end else if (seen_eq_d || seen_semi_d) begin
        if (seen_semi_d) begin
          jcode = jump_lookup(tok_chars_d, tok_len_d);
          if (jcode == 3'd0) begin
            err_d = note_err(err_d, ERR_JUMP);
          end
        end else begin
          cres = comp_lookup(tok_chars_d, tok_len_d);
          if (!cres.hit) begin
            err_d = note_err(err_d, ERR_COMP);
          end else begin
            comp_d = cres.code;
          end
        end
        res.kind = KIND_COMP;
        res.err  = err_d;
        res.word = (err_d != ERR_OK) ? 16'd0 : {3'b111, comp_d, dest_d, jcode};
      end
      // back to line start
      ph          = PH_START;
      tok_chars_d = '0;
      tok_len_d   = 3'd0;
      dest_d      = 3'd0;
      comp_d      = 7'd0;
      addr_d      = '0;
      err_d       = ERR_OK;
      seen_eq_d   = 1'b0;
      seen_semi_d = 1'b0;
    end
    phase_d = ph;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (q_pop_o && q_entry_i.last) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      tok_chars_q <= '0;
      tok_len_q   <= 3'd0;
      dest_q      <= 3'd0;
      comp_q      <= 7'd0;
      addr_q      <= '0;
      err_q       <= ERR_OK;
      seen_eq_q   <= 1'b0;
      seen_semi_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q     <= phase_d;
        tok_chars_q <= tok_chars_d;
        tok_len_q   <= tok_len_d;
        dest_q      <= dest_d;
        comp_q      <= comp_d;
        addr_q      <= addr_d;
        err_q       <= err_d;
        seen_eq_q   <= seen_eq_d;
        seen_semi_q <= seen_semi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.err, out_q.word};
  assign m_axis_tuser  = out_q.kind;

endmodule

// ===== rtl/core/assembly_line_instruction_encoder.sv =====
// Encodes one assembly line, fed one character per beat, into a 16-bit
// instruction word. The block takes one character per clock cycle, with
// no gaps, as long as the result side keeps up: the front classifies each
// character into a four-entry queue, and the back parses one queued
// character per cycle, so the rate is set by the back's per-character parse step.
// A line's result is loaded into the output register at the same edge at
// which its last character leaves the queue; each character that is taken
// is held in the queue storage first. Characters that are not the last of a
// line keep flowing while a result waits on the output. Lines starting with
// '@' give an address instruction; other lines with '=' or ';' give a compute
// instruction; anything else gives kind zero and a zero word.
// Depends on alie_pkg, alie_front, alie_queue and alie_back.

module assembly_line_instruction_encoder
  import alie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] ch
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] word, [18:16] error, zero pad
  output logic [1:0]  m_axis_tuser   // [1:0] kind
);

  logic    q_full;
  logic    q_push;
  qentry_t q_wr_entry;
  logic    q_pop;
  qentry_t q_rd_entry;
  logic    q_empty;

  // character classifier
  alie_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wr_entry)
  );

  // decoupling queue
  alie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  // parser and encoder
  alie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/alie_checker.sv =====
// alie_checker: port-level checks on encoded results, bound to the top level.
// Depends on alie_pkg and assembly_line_instruction_encoder.

module alie_checker
  import alie_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a non-instruction line carries no word and no error
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_NONE |-> m_axis_tdata == 24'd0)
    else $error("non-instruction result not zero");

  // only address overflow keeps a word alongside an error
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18:16] != ERR_OK &&
      m_axis_tdata[18:16] != ERR_ADDR_OVF |-> m_axis_tdata[15:0] == 16'd0)
    else $error("word not cleared on error");

  // address words have a clear opcode bit, compute words the 111 prefix
  a_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18:16] == ERR_OK |->
      (m_axis_tuser == KIND_ADDR && !m_axis_tdata[15]) ||
      (m_axis_tuser == KIND_COMP && m_axis_tdata[15:13] == 3'b111) ||
      (m_axis_tuser == KIND_NONE))
    else $error("opcode bits do not match kind");

endmodule

bind assembly_line_instruction_encoder alie_checker u_checker (.*);
